/* hdl/socg_pkg.sv */
package socg_pkg;

    // default table size
    localparam int TABLE_DEPTH_DEF = 8;

    // request codes
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_CAL  = 2'd1;
    localparam logic [1:0] REQ_LOAD = 2'd2;

    // current source modes
    localparam logic [1:0] SRC_RELAY = 2'd1;
    localparam logic [1:0] SRC_EXT   = 2'd2;

    // gauge state codes
    localparam logic [1:0] GS_IDLE      = 2'd0;
    localparam logic [1:0] GS_CHARGE    = 2'd1;
    localparam logic [1:0] GS_DISCHARGE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_CAPACITY  = 3'd0;
    localparam logic [2:0] REG_EFF       = 3'd1;
    localparam logic [2:0] REG_REST_I    = 3'd2;
    localparam logic [2:0] REG_REST_T    = 3'd3;
    localparam logic [2:0] REG_CELLS     = 3'd4;
    localparam logic [2:0] REG_PRESENT   = 3'd5;
    localparam logic [2:0] REG_LOAD_I    = 3'd6;
    localparam logic [2:0] REG_SRC_MODE  = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 27;

    // serial divider widths
    localparam int DIV_REM_W = 32;
    localparam int DIV_Q_W   = 23;

    // shared multiplier widths
    localparam int MUL_A_W = 39;
    localparam int MUL_B_W = 17;

    // percent scale, charge unit and presence threshold constants
    localparam logic [22:0] FULL_Q16   = 23'd6553600;
    localparam logic [15:0] UNITS_Q16  = 16'd36000;
    localparam logic [12:0] PRESENT_DEF = 13'd2000;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [15:0]        delta_ms;
        logic [15:0]        vbat_mv;
        logic signed [15:0] ibat_ma;
        logic [14:0]        ext_discharge_ma;
        logic [2:0]         point_index;
        logic [15:0]        point_mv;
        logic [6:0]         point_pct;
        logic [3:0]         table_points;
    } gauge_in_t;

    typedef struct packed {
        logic [6:0]  soc_percent;
        logic [22:0] soc_fraction;
        logic [1:0]  gauge_state;
        logic        is_calibrated;
    } gauge_out_t;

    // divider request
    typedef struct packed {
        logic                 start;
        logic [DIV_REM_W-1:0] rem_init;
        logic [DIV_Q_W-1:0]   low;
        logic [DIV_REM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CAPD,
        ST_CAPF,
        ST_CELL_GO,
        ST_CELL_WAIT,
        ST_DECIDE,
        ST_MAG,
        ST_EFF,
        ST_ACC,
        ST_SOC_GO,
        ST_SOC_WAIT,
        ST_T_FIRST,
        ST_T_LAST,
        ST_T_SCAN,
        ST_IMUL,
        ST_IDIV_GO,
        ST_IDIV_WAIT,
        ST_CMUL1,
        ST_CMUL2,
        ST_DONE
    } gauge_state_t;

endpackage

/* hdl/battery_soc_coulomb_ocv_gauge.sv */
// s_ready rises together with m_valid, so a new item can be taken while
// the last result is still held; the shared serial divider takes 23 steps
// per pass and a tick that recalibrates uses it up to three times
// synchronous active-low reset restores register defaults and clears the
// gauge state; table contents are undefined until loaded
module battery_soc_coulomb_ocv_gauge #(
    parameter int TABLE_DEPTH = socg_pkg::TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  socg_pkg::gauge_in_t              s_item,
    output logic                             m_valid,
    input  logic                             m_ready,
    output socg_pkg::gauge_out_t             m_item,
    input  logic                             cfg_we,
    input  logic [socg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [socg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import socg_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = 23;

    // configuration registers
    logic [15:0] cap_mah_reg;
    logic [16:0] eff_reg;
    logic [14:0] rest_i_reg;
    logic [26:0] rest_t_reg;
    logic [4:0]  cells_reg;
    logic [12:0] present_reg;
    logic [14:0] load_i_reg;
    logic [1:0]  src_mode_reg;

    // gauge state
    logic [37:0] charge_reg;
    logic [22:0] soc_reg;
    logic [1:0]  ms_reg;
    logic [31:0] rest_reg;
    logic        calib_reg;
    logic        recon_reg;
    logic [CW-1:0] npts_reg;
    logic [EW-1:0] tbl [TABLE_DEPTH];

    // work registers
    gauge_state_t state_reg, state_next;
    gauge_in_t    item_reg;
    logic [31:0]  dq_reg;
    logic [37:0]  capu_reg;
    logic [15:0]  cmv_reg;
    logic [38:0]  tmp_reg;
    logic         do_cal_reg;
    logic         chg_reg;
    logic [14:0]  mag_reg;
    logic [IW-1:0] scan_reg;
    logic [15:0]  v0_reg, v1_reg;
    logic [6:0]   s0_reg, s1_reg;

    // output register
    logic        m_valid_reg;
    gauge_out_t  m_item_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] prod;
    logic [IW-1:0]              rd_idx;
    logic [EW-1:0]              entry;
    logic [15:0]                entry_mv;
    logic [6:0]                 entry_pct;
    logic [IW-1:0]              last_idx;

    // effective register values
    logic [15:0] cap_eff;
    logic [16:0] eff_eff;
    logic [4:0]  cells_eff;
    logic [12:0] present_eff;

    // decision outputs
    logic signed [15:0] ibat_s;
    logic [14:0] absi;
    logic [1:0]  ms_d;
    logic [31:0] rest_d;
    logic        recon_d;
    logic        integ_d;
    logic        chg_d;
    logic [14:0] mag_d;
    logic        cal_d;

    logic        up_dir;
    logic [6:0]  span;
    logic [24:0] interp_r;
    logic [38:0] acc_sum;
    logic [37:0] acc_new;
    logic [23:0] round_sum;
    logic        accept_in;
    logic        out_load;

    assign cap_eff     = (cap_mah_reg == '0) ? 16'd1 : cap_mah_reg;
    assign eff_eff     = (eff_reg == '0 || eff_reg > 17'd65536) ? 17'd65536 : eff_reg;
    assign cells_eff   = (cells_reg == '0) ? 5'd1 : cells_reg;
    assign present_eff = (present_reg == '0) ? PRESENT_DEF : present_reg;

    assign accept_in = s_valid && s_ready;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // clamp a percent value to full scale
    function automatic logic [22:0] sat_soc(input logic [24:0] v);
        sat_soc = (v > {2'b00, FULL_Q16}) ? FULL_Q16 : v[22:0];
    endfunction

    socg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // shared multiplier
    assign prod = mul_a * mul_b;

    // table read port
    assign last_idx  = IW'(npts_reg - 1'b1);
    assign entry     = tbl[rd_idx];
    assign entry_mv  = entry[EW-1:7];
    assign entry_pct = entry[6:0];

    // interpolation helpers
    assign up_dir   = (s1_reg >= s0_reg);
    assign span     = up_dir ? (s1_reg - s0_reg) : (s0_reg - s1_reg);
    assign interp_r = up_dir ? ({2'b00, s0_reg, 16'b0} + {2'b00, div_rsp.quotient})
                             : ({2'b00, s0_reg, 16'b0} - {2'b00, div_rsp.quotient});

    // charge accumulate and clamp
    always_comb begin
        if (chg_reg) begin
            acc_sum = {1'b0, charge_reg} + {7'b0, tmp_reg[31:0]};
        end else if ({7'b0, tmp_reg[31:0]} >= {1'b0, charge_reg}) begin
            acc_sum = '0;
        end else begin
            acc_sum = {1'b0, charge_reg} - {7'b0, tmp_reg[31:0]};
        end
        acc_new = (acc_sum > {1'b0, capu_reg}) ? capu_reg : acc_sum[37:0];
    end

    // tick decision: mode, rest timer, integration and recalibration
    always_comb begin
        logic        hr;
        logic [14:0] habs;
        logic [32:0] rsum;
        logic [31:0] rsat;
        ibat_s  = (item_reg.ibat_ma == 16'sh8000) ? 16'sh8001 : item_reg.ibat_ma;
        absi    = ibat_s[15] ? 15'(-ibat_s) : ibat_s[14:0];
        ms_d    = ms_reg;
        rest_d  = rest_reg;
        recon_d = recon_reg;
        integ_d = 1'b0;
        chg_d   = 1'b0;
        mag_d   = '0;
        cal_d   = 1'b0;
        hr      = 1'b0;
        habs    = absi;
        rsum    = {1'b0, rest_reg} + {17'b0, item_reg.delta_ms};
        rsat    = rsum[32] ? 32'hFFFF_FFFF : rsum[31:0];
        if (src_mode_reg == SRC_RELAY) begin
            if (cmv_reg >= {3'b0, present_eff}) begin
                if (ibat_s > 0) begin
                    ms_d    = GS_CHARGE;
                    integ_d = 1'b1;
                    chg_d   = 1'b1;
                    mag_d   = absi;
                end
                hr = 1'b1;
            end else begin
                if (ms_reg != GS_DISCHARGE) begin
                    recon_d = 1'b1;
                    rest_d  = '0;
                end
                ms_d = GS_DISCHARGE;
                if (load_i_reg != '0) begin
                    integ_d = 1'b1;
                    mag_d   = load_i_reg;
                end
            end
        end else if (src_mode_reg == SRC_EXT) begin
            if (ibat_s > 0) begin
                ms_d    = GS_CHARGE;
                integ_d = 1'b1;
                chg_d   = 1'b1;
                mag_d   = absi;
            end else begin
                habs = item_reg.ext_discharge_ma;
                if (item_reg.ext_discharge_ma >= rest_i_reg) begin
                    ms_d    = GS_DISCHARGE;
                    integ_d = 1'b1;
                    mag_d   = item_reg.ext_discharge_ma;
                end
            end
            hr = 1'b1;
        end else begin
            if (absi >= rest_i_reg) begin
                ms_d    = (ibat_s > 0) ? GS_CHARGE : GS_DISCHARGE;
                integ_d = 1'b1;
                chg_d   = (ibat_s > 0);
                mag_d   = absi;
            end
            hr = 1'b1;
        end
        if (hr) begin
            if (habs < rest_i_reg) begin
                ms_d = GS_IDLE;
                if (recon_d || rsat >= {5'b0, rest_t_reg}) begin
                    cal_d   = 1'b1;
                    rest_d  = '0;
                    recon_d = 1'b0;
                end else begin
                    rest_d = rsat;
                end
            end else begin
                rest_d = '0;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    if (s_item.req_type == REQ_TICK || s_item.req_type == REQ_CAL) begin
                        state_next = ST_CAPD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CAPD:    state_next = ST_CAPF;
            ST_CAPF:    state_next = ST_CELL_GO;
            ST_CELL_GO: state_next = ST_CELL_WAIT;
            ST_CELL_WAIT: begin
                if (div_rsp.done) begin
                    if (item_reg.req_type == REQ_CAL) begin
                        state_next = (npts_reg == '0) ? ST_CMUL1 : ST_T_FIRST;
                    end else begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (integ_d) begin
                    state_next = ST_MAG;
                end else if (cal_d) begin
                    state_next = (npts_reg == '0) ? ST_CMUL1 : ST_T_FIRST;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_MAG:    state_next = chg_reg ? ST_EFF : ST_ACC;
            ST_EFF:    state_next = ST_ACC;
            ST_ACC:    state_next = ST_SOC_GO;
            ST_SOC_GO: state_next = ST_SOC_WAIT;
            ST_SOC_WAIT: begin
                if (div_rsp.done) begin
                    if (do_cal_reg) begin
                        state_next = (npts_reg == '0) ? ST_CMUL1 : ST_T_FIRST;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_T_FIRST: state_next = (cmv_reg <= entry_mv) ? ST_CMUL1 : ST_T_LAST;
            ST_T_LAST:  state_next = (cmv_reg >= entry_mv) ? ST_CMUL1 : ST_T_SCAN;
            ST_T_SCAN: begin
                if (cmv_reg <= entry_mv || scan_reg == last_idx) begin
                    state_next = ST_IMUL;
                end
            end
            ST_IMUL:    state_next = ST_IDIV_GO;
            ST_IDIV_GO: state_next = ST_IDIV_WAIT;
            ST_IDIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = ST_CMUL1;
                end
            end
            ST_CMUL1: state_next = ST_CMUL2;
            ST_CMUL2: state_next = ST_DONE;
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // unit controls per state
    always_comb begin
        s_ready          = (state_reg == ST_IDLE);
        mul_a            = '0;
        mul_b            = '0;
        rd_idx           = scan_reg;
        div_req.start    = 1'b0;
        div_req.rem_init = '0;
        div_req.low      = '0;
        div_req.divisor  = {27'b0, cells_eff};
        unique case (state_reg)
            ST_CAPD: begin
                mul_a = MUL_A_W'(cap_eff);
                mul_b = MUL_B_W'(UNITS_Q16);
            end
            ST_CAPF: begin
                mul_a = MUL_A_W'(dq_reg);
                mul_b = MUL_B_W'(100);
            end
            ST_CELL_GO: begin
                div_req.start = 1'b1;
                div_req.low   = {7'b0, item_reg.vbat_mv};
            end
            ST_MAG: begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = MUL_B_W'(item_reg.delta_ms);
            end
            ST_EFF: begin
                mul_a = MUL_A_W'(tmp_reg[31:0]);
                mul_b = eff_eff;
            end
            ST_SOC_GO: begin
                div_req.start    = 1'b1;
                div_req.rem_init = {1'b0, charge_reg[37:7]};
                div_req.low      = {charge_reg[6:0], 16'b0};
                div_req.divisor  = dq_reg;
            end
            ST_T_FIRST: rd_idx = '0;
            ST_T_LAST:  rd_idx = last_idx;
            ST_IMUL: begin
                mul_a = MUL_A_W'(cmv_reg - v0_reg);
                mul_b = MUL_B_W'(span);
            end
            ST_IDIV_GO: begin
                div_req.start    = 1'b1;
                div_req.rem_init = {16'b0, tmp_reg[22:7]};
                div_req.low      = {tmp_reg[6:0], 16'b0};
                div_req.divisor  = {16'b0, v1_reg - v0_reg};
            end
            ST_CMUL1: begin
                mul_a = MUL_A_W'(soc_reg);
                mul_b = MUL_B_W'(cap_eff);
            end
            ST_CMUL2: begin
                mul_a = tmp_reg;
                mul_b = MUL_B_W'(UNITS_Q16);
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_mah_reg  <= 16'd1000;
            eff_reg      <= 17'd65536;
            rest_i_reg   <= 15'd50;
            rest_t_reg   <= 27'd1800000;
            cells_reg    <= 5'd1;
            present_reg  <= 13'd2000;
            load_i_reg   <= '0;
            src_mode_reg <= '0;
            charge_reg   <= '0;
            soc_reg      <= '0;
            ms_reg       <= GS_IDLE;
            rest_reg     <= '0;
            calib_reg    <= 1'b0;
            recon_reg    <= 1'b0;
            npts_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            // register writes
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_CAPACITY: cap_mah_reg  <= cfg_data[15:0];
                    REG_EFF:      eff_reg      <= cfg_data[16:0];
                    REG_REST_I:   rest_i_reg   <= cfg_data[14:0];
                    REG_REST_T:   rest_t_reg   <= cfg_data[26:0];
                    REG_CELLS:    cells_reg    <= cfg_data[4:0];
                    REG_PRESENT:  present_reg  <= cfg_data[12:0];
                    REG_LOAD_I:   load_i_reg   <= cfg_data[14:0];
                    REG_SRC_MODE: src_mode_reg <= cfg_data[1:0];
                    default: begin
                    end
                endcase
            end

            // table point count
            if (accept_in && s_item.req_type == REQ_LOAD) begin
                if (32'(s_item.table_points) > TABLE_DEPTH) begin
                    npts_reg <= CW'(TABLE_DEPTH);
                end else begin
                    npts_reg <= CW'(s_item.table_points);
                end
            end

            // tick decision
            if (state_reg == ST_DECIDE) begin
                ms_reg    <= ms_d;
                rest_reg  <= rest_d;
                recon_reg <= recon_d;
            end

            // charge and percent updates
            if (state_reg == ST_ACC) begin
                charge_reg <= acc_new;
            end
            if (state_reg == ST_SOC_WAIT && div_rsp.done) begin
                soc_reg <= div_rsp.quotient;
            end
            if (state_reg == ST_T_FIRST && cmv_reg <= entry_mv) begin
                soc_reg <= sat_soc({2'b00, entry_pct, 16'b0});
            end
            if (state_reg == ST_T_LAST && cmv_reg >= entry_mv) begin
                soc_reg <= sat_soc({2'b00, entry_pct, 16'b0});
            end
            if (state_reg == ST_IDIV_WAIT && div_rsp.done) begin
                soc_reg <= sat_soc(interp_r);
            end
            if (state_reg == ST_CMUL2) begin
                charge_reg <= prod[53:16];
                calib_reg  <= 1'b1;
            end

            // result transfer
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            item_reg <= s_item;
        end
        if (accept_in && s_item.req_type == REQ_LOAD
            && 32'(s_item.point_index) < TABLE_DEPTH) begin
            tbl[IW'(s_item.point_index)] <= {s_item.point_mv, s_item.point_pct};
        end
        unique case (state_reg)
            ST_CAPD: dq_reg   <= prod[31:0];
            ST_CAPF: capu_reg <= prod[37:0];
            ST_CELL_WAIT: begin
                if (div_rsp.done) begin
                    cmv_reg    <= div_rsp.quotient[15:0];
                    do_cal_reg <= 1'b1;
                end
            end
            ST_DECIDE: begin
                do_cal_reg <= cal_d;
                chg_reg    <= chg_d;
                mag_reg    <= mag_d;
            end
            ST_MAG: tmp_reg <= {8'b0, prod[30:0]};
            ST_EFF: tmp_reg <= {7'b0, prod[47:16]};
            ST_T_FIRST: begin
                v0_reg   <= entry_mv;
                s0_reg   <= entry_pct;
                scan_reg <= IW'(1);
            end
            ST_T_SCAN: begin
                if (cmv_reg <= entry_mv || scan_reg == last_idx) begin
                    v1_reg <= entry_mv;
                    s1_reg <= entry_pct;
                end else begin
                    v0_reg   <= entry_mv;
                    s0_reg   <= entry_pct;
                    scan_reg <= scan_reg + 1'b1;
                end
            end
            ST_IMUL:  tmp_reg <= {16'b0, prod[22:0]};
            ST_CMUL1: tmp_reg <= prod[38:0];
            default: begin
            end
        endcase
        if (out_load) begin
            m_item_reg.soc_percent   <= round_sum[22:16];
            m_item_reg.soc_fraction  <= soc_reg;
            m_item_reg.gauge_state   <= ms_reg;
            m_item_reg.is_calibrated <= calib_reg;
        end
    end

    // round half up to whole percent
    assign round_sum = {1'b0, soc_reg} + 24'd32768;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

/* hdl/socg_div.sv */
module socg_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  socg_pkg::div_req_t req,
    output socg_pkg::div_rsp_t rsp
);
    import socg_pkg::*;

    localparam int CNT_W = $clog2(DIV_Q_W + 1);

    logic [DIV_REM_W-1:0] rem_reg, rem_next;
    logic [DIV_Q_W-1:0]   low_reg, low_next;
    logic [DIV_Q_W-1:0]   q_reg, q_next;
    logic [DIV_REM_W-1:0] d_reg;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_REM_W:0]   trial;
    logic [DIV_REM_W:0]   diff;

    // one restoring step per cycle while busy
    always_comb begin
        trial     = {rem_reg, low_reg[DIV_Q_W-1]};
        diff      = trial - {1'b0, d_reg};
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.rem_init;
            low_next  = req.low;
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                rem_next = diff[DIV_REM_W-1:0];
                q_next   = {q_reg[DIV_Q_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_REM_W-1:0];
                q_next   = {q_reg[DIV_Q_W-2:0], 1'b0};
            end
            low_next = {low_reg[DIV_Q_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_Q_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        if (req.start) begin
            d_reg <= req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule
